// File: rtl/cdr_pkg.sv
// Package for the calendar date register: item, date and result types,
// action and status codes, and the leap-year and month-length helpers.
// No dependencies.
package cdr_pkg;

  // Action codes
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_INC  = 2'd1;
  localparam logic [1:0] ACT_DIFF = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NODATE  = 2'd2;

  // Config register indexes
  localparam logic CFG_MIN_YEAR = 1'b0;
  localparam logic CFG_MAX_YEAR = 1'b1;

  localparam logic [11:0] MIN_YEAR_RST = 12'd1800;
  localparam logic [11:0] MAX_YEAR_RST = 12'd2050;

  // Inverse of 25 modulo 4096 and the largest multiple count below 4096
  localparam logic [11:0] INV25     = 12'd3113;
  localparam logic [11:0] DIV25_MAX = 12'd163;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } date_t;

  // Listed from the top bit down, so action sits in the lowest bits
  typedef struct packed {
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [1:0]  action;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         cur_day;
    logic [3:0]         cur_month;
    logic [11:0]        cur_year;
    logic signed [12:0] diff_years;
    logic signed [4:0]  diff_months;
    logic [4:0]         diff_days;
  } result_t;

  // Non-leap month length, zero for codes outside 1..12
  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
      4'd2:                                       month_len = 5'd28;
      default:                                    month_len = 5'd0;
    endcase
  endfunction

  // Divisible by 4 and not by 100, or by 400. Divisibility by 25 via the
  // modular inverse: y*inv(25) mod 4096 stays at or below 4095/25.
  function automatic logic is_leap(input logic [11:0] y);
    logic [23:0] p;
    logic        by25;
    p    = {12'd0, y} * {12'd0, INV25};
    by25 = (p[11:0] <= DIV25_MAX);
    is_leap = (y[1:0] == 2'd0) && (!by25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic [11:0] y);
    if (m == 4'd2 && is_leap(y)) begin
      days_in = 5'd29;
    end else begin
      days_in = month_len(m);
    end
  endfunction

endpackage

// File: rtl/cdr_step.sv
// Next-state and result logic for one item of the calendar date register.
// Depends on cdr_pkg.
module cdr_step (
  input  cdr_pkg::item_t   item,
  input  cdr_pkg::date_t   date,
  input  logic [11:0]      min_year,
  input  logic [11:0]      max_year,
  output cdr_pkg::date_t   date_nxt,
  output cdr_pkg::result_t res
);

  logic              given_ok;
  logic              have_date;
  logic [4:0]        cur_len;
  logic [5:0]        inc_day;
  logic [3:0]        inc_month;
  logic [12:0]       inc_year;
  logic signed [12:0] dy;
  logic signed [4:0]  dm;
  logic [5:0]         dd;

  // Given-date validation
  always_comb begin
    given_ok = (item.in_year >= min_year) && (item.in_year <= max_year) &&
               (item.in_month >= 4'd1) && (item.in_month <= 4'd12) &&
               (item.in_day >= 5'd1) &&
               (item.in_day <= cdr_pkg::days_in(item.in_month, item.in_year));
    have_date = (date.month >= 4'd1) && (date.month <= 4'd12);
  end

  // One-day advance with month and year rollover
  always_comb begin
    cur_len   = cdr_pkg::days_in(date.month, date.year);
    inc_day   = {1'b0, date.day} + 6'd1;
    inc_month = date.month;
    inc_year  = {1'b0, date.year};
    if (inc_day > {1'b0, cur_len}) begin
      inc_day = 6'd1;
      if (date.month == 4'd12) begin
        inc_month = 4'd1;
        inc_year  = {1'b0, date.year} + 13'd1;
      end else begin
        inc_month = date.month + 4'd1;
      end
    end
  end

  // Difference with borrow by the given month's non-leap length
  always_comb begin
    dy = $signed({1'b0, date.year}) - $signed({1'b0, item.in_year});
    if (date.month < item.in_month) begin
      dy = dy - 13'sd1;
      dm = $signed(5'd12 - {1'b0, item.in_month} + {1'b0, date.month});
    end else begin
      dm = $signed({1'b0, date.month} - {1'b0, item.in_month});
    end
    if (date.day < item.in_day) begin
      dm = dm - 5'sd1;
      dd = {1'b0, cdr_pkg::month_len(item.in_month)} - {1'b0, item.in_day} +
           {1'b0, date.day};
    end else begin
      dd = {1'b0, date.day} - {1'b0, item.in_day};
    end
  end

  // Action select
  always_comb begin
    date_nxt        = date;
    res.status      = cdr_pkg::ST_OK;
    res.diff_years  = '0;
    res.diff_months = '0;
    res.diff_days   = '0;
    case (item.action)
      cdr_pkg::ACT_LOAD: begin
        if (given_ok) begin
          date_nxt.day   = item.in_day;
          date_nxt.month = item.in_month;
          date_nxt.year  = item.in_year;
        end else begin
          res.status = cdr_pkg::ST_INVALID;
        end
      end
      cdr_pkg::ACT_INC: begin
        if (!have_date || inc_year[12]) begin
          res.status = cdr_pkg::ST_NODATE;
        end else begin
          date_nxt.day   = inc_day[4:0];
          date_nxt.month = inc_month;
          date_nxt.year  = inc_year[11:0];
        end
      end
      cdr_pkg::ACT_DIFF: begin
        if (!given_ok) begin
          res.status = cdr_pkg::ST_INVALID;
        end else if (!have_date) begin
          res.status = cdr_pkg::ST_NODATE;
        end else begin
          res.diff_years  = dy;
          res.diff_months = dm;
          res.diff_days   = dd[4:0];
        end
      end
      default: ;
    endcase
    res.cur_day   = date_nxt.day;
    res.cur_month = date_nxt.month;
    res.cur_year  = date_nxt.year;
  end

endmodule

// File: rtl/calendar_date_register.sv
// Calendar date register: input register, combinational step logic, result register.
// An item passes from the input register through the step logic into the result
// register. Throughput: one item per cycle while out_tready holds; each item sees the date
// left by the previous one.
// Reset (rst_n low, synchronous): no date stored, limits back to 1800..2050,
// both stages empty.
// Depends on cdr_pkg and cdr_step.
module calendar_date_register (
  input  logic        clk,
  input  logic        rst_n,
  // Config write port
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [11:0] cfg_wdata,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // action[1:0], in_day[6:2], in_month[10:7], in_year[22:11]
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[1:0], cur_day[6:2], cur_month[10:7],
                                  // cur_year[22:11], diff_years[35:23],
                                  // diff_months[40:36], diff_days[45:41]
);

  logic              in_valid_r;
  cdr_pkg::item_t    item_r;
  logic              out_valid_r;
  cdr_pkg::result_t  res_r;
  cdr_pkg::result_t  res_nxt;
  cdr_pkg::date_t    date_r;
  cdr_pkg::date_t    date_nxt;
  logic [11:0]       min_year_r;
  logic [11:0]       max_year_r;
  logic              advance;

  // The step stage moves when the result register is free or draining
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= cdr_pkg::MIN_YEAR_RST;
      max_year_r <= cdr_pkg::MAX_YEAR_RST;
    end else if (cfg_wr_en) begin
      if (cfg_addr == cdr_pkg::CFG_MIN_YEAR) begin
        min_year_r <= cfg_wdata;
      end else begin
        max_year_r <= cfg_wdata;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= cdr_pkg::item_t'(in_tdata[22:0]);
    end
  end

  cdr_step u_step (
    .item     (item_r),
    .date     (date_r),
    .min_year (min_year_r),
    .max_year (max_year_r),
    .date_nxt (date_nxt),
    .res      (res_nxt)
  );

  // Stored date and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      date_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        date_r <= date_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.diff_days, res_r.diff_months, res_r.diff_years,
                       res_r.cur_year, res_r.cur_month, res_r.cur_day, res_r.status};

endmodule
